### rtl/core/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants of the midpoint circle rasterizer
// Field widths, operation and register codes, and the pixel group that
// travels from the circle stepper to the pixel emitter.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int unsigned CENTER_W   = 12;
  localparam int unsigned RADIUS_W   = 11;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned DECISION_W = 16;
  localparam int unsigned PIXEL_W    = 14;
  localparam int unsigned COLOR_W    = 8;

  // Stream words, padded to whole bytes.
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 40;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd3;

  // Input operation codes, carried on tuser.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_PIXEL_COLOR = 1'b0;

  localparam int unsigned PIX_IDX_W = 3;
  localparam logic [PIX_IDX_W-1:0] PIX_IDX_LAST = 3'd7;

  typedef struct packed {
    logic [CENTER_W-1:0]        cx;
    logic [CENTER_W-1:0]        cy;
    logic signed [OFFSET_W-1:0] a;
    logic signed [OFFSET_W-1:0] b;
    logic                       done;
  } group_t;

endpackage

### rtl/core/midpoint_circle_rasterizer_top.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top: Bresenham midpoint circle generator
// A start word latches center and radius and yields the first pixel group;
// each step word while the circle runs advances it one column and yields the next group.
// The first pixel of a group leaves from the emitter register, after the word has passed the group stage.
// Throughput: one pixel per cycle on the output stream while m_axis_tready_i is
// high; a step word while idle is taken and yields no group.
// The single-pixel output stage sets the rate; one group waits behind it.
// Reset (rst_ni low, asynchronous) empties both stages, stops the circle
// and sets pixel_color to 3.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: center_x[11:0], center_y[23:12], radius[34:24], zero[39:35]
  input  logic [mcr_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,
  // tuser: op
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: pixel_x[13:0], pixel_y[27:14], color[35:28], zero[39:36]
  output logic [mcr_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  // tuser: circle_done
  output logic                               m_axis_tuser_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mcr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mcr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mcr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned CW =
      (COORD_BITS < mcr_pkg::CENTER_W) ? COORD_BITS : mcr_pkg::CENTER_W;

  logic [mcr_pkg::COLOR_W-1:0]           pixel_color_q;
  logic [CW-1:0]                         center_x_q, center_x_d;
  logic [CW-1:0]                         center_y_q, center_y_d;
  logic signed [mcr_pkg::OFFSET_W-1:0]   offset_x_q, offset_x_d;
  logic signed [mcr_pkg::OFFSET_W-1:0]   offset_y_q, offset_y_d;
  logic signed [mcr_pkg::DECISION_W-1:0] decision_q, decision_d;
  logic                                  running_q, running_d;

  mcr_pkg::group_t                       grp_q, grp_d;
  logic                                  grp_valid_q;
  logic                                  grp_take;
  logic                                  grp_new;

  logic                                  in_hs;
  logic                                  op;
  logic [mcr_pkg::CENTER_W-1:0]          in_cx;
  logic [mcr_pkg::CENTER_W-1:0]          in_cy;
  logic [mcr_pkg::RADIUS_W-1:0]          in_radius;
  logic signed [mcr_pkg::OFFSET_W-1:0]   x_inc;
  logic signed [mcr_pkg::OFFSET_W-1:0]   y_next;
  logic [mcr_pkg::DECISION_W-1:0]        diff;
  logic [mcr_pkg::DECISION_W-1:0]        r_ext;
  logic                                  d_pos;
  logic                                  cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == mcr_pkg::REG_PIXEL_COLOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_color_q <= mcr_pkg::COLOR_RESET;
    end else if (cfg_wr) begin
      pixel_color_q <= pwdata[mcr_pkg::COLOR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == mcr_pkg::REG_PIXEL_COLOR) ?
                  mcr_pkg::APB_DATA_W'(pixel_color_q) : '0;

  // Input side. The group stage is the input register of the block.
  assign s_axis_tready_o = !grp_valid_q;
  assign in_hs     = s_axis_tvalid_i && s_axis_tready_o;
  assign op        = s_axis_tuser_i;
  assign in_cx     = s_axis_tdata_i[11:0];
  assign in_cy     = s_axis_tdata_i[23:12];
  assign in_radius = s_axis_tdata_i[34:24];

  always_comb begin
    center_x_d = center_x_q;
    center_y_d = center_y_q;
    offset_x_d = offset_x_q;
    offset_y_d = offset_y_q;
    decision_d = decision_q;
    running_d  = running_q;
    grp_d      = grp_q;
    grp_new    = 1'b0;

    r_ext  = mcr_pkg::DECISION_W'(in_radius);
    x_inc  = offset_x_q + 1'b1;
    d_pos  = !decision_q[mcr_pkg::DECISION_W-1] && (decision_q != '0);
    y_next = d_pos ? (offset_y_q - 1'b1) : offset_y_q;
    diff   = mcr_pkg::DECISION_W'(x_inc) - mcr_pkg::DECISION_W'(y_next);

    if (in_hs) begin
      if (op == mcr_pkg::OP_START) begin
        center_x_d = CW'(in_cx);
        center_y_d = CW'(in_cy);
        offset_x_d = '0;
        offset_y_d = mcr_pkg::OFFSET_W'(in_radius);
        decision_d = 16'sd3 - signed'(r_ext << 1);
        running_d  = 1'b1;
        grp_d.cx   = mcr_pkg::CENTER_W'(center_x_d);
        grp_d.cy   = mcr_pkg::CENTER_W'(center_y_d);
        grp_d.a    = '0;
        grp_d.b    = offset_y_d;
        grp_d.done = 1'b0;
        grp_new    = 1'b1;
      end else if (running_q) begin
        offset_x_d = x_inc;
        offset_y_d = y_next;
        if (d_pos) begin
          decision_d = decision_q + signed'(diff << 2) + 16'sd10;
        end else begin
          decision_d = decision_q + signed'(mcr_pkg::DECISION_W'(x_inc) << 2) + 16'sd6;
        end
        grp_d.cx   = mcr_pkg::CENTER_W'(center_x_q);
        grp_d.cy   = mcr_pkg::CENTER_W'(center_y_q);
        grp_d.a    = x_inc;
        grp_d.b    = y_next;
        grp_d.done = (y_next < x_inc);
        running_d  = !grp_d.done;
        grp_new    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= '0;
      center_y_q  <= '0;
      offset_x_q  <= '0;
      offset_y_q  <= '0;
      decision_q  <= '0;
      running_q   <= 1'b0;
      grp_valid_q <= 1'b0;
    end else begin
      center_x_q <= center_x_d;
      center_y_q <= center_y_d;
      offset_x_q <= offset_x_d;
      offset_y_q <= offset_y_d;
      decision_q <= decision_d;
      running_q  <= running_d;
      if (grp_new) begin
        grp_valid_q <= 1'b1;
      end else if (grp_take) begin
        grp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_new) begin
      grp_q <= grp_d;
    end
  end

  mcr_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .group_i         (grp_q),
    .group_valid_i   (grp_valid_q),
    .group_ready_o   (grp_take),
    .color_i         (pixel_color_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // A step word while idle must not create a group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_hs && op == mcr_pkg::OP_STEP && !running_q) |=> !grp_valid_q)
    else $error("step while idle produced a pixel group");

  // A start word always leaves a running circle and a pending group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_hs && op == mcr_pkg::OP_START) |=> (running_q && grp_valid_q))
    else $error("start word did not begin a circle");

  // A pending group is handed on once the emitter takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grp_valid_q && grp_take) |=> !grp_valid_q)
    else $error("pixel group stayed pending after handoff");

endmodule

### rtl/core/mcr_emitter.sv
// ----------------------------------------------------------------------------
// mcr_emitter: pixel group to pixel stream
// Holds one eight-way symmetric group and sends its eight pixels, one word
// per cycle while m_axis_tready_i is high, in octant order.
// ----------------------------------------------------------------------------
module mcr_emitter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mcr_pkg::group_t                    group_i,
  input  logic                               group_valid_i,
  output logic                               group_ready_o,
  input  logic [mcr_pkg::COLOR_W-1:0]        color_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: pixel_x[13:0], pixel_y[27:14], color[35:28], zero[39:36]
  output logic [mcr_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  // tuser: circle_done
  output logic                               m_axis_tuser_o
);

  mcr_pkg::group_t                   grp_q;
  logic                              valid_q;
  logic [mcr_pkg::PIX_IDX_W-1:0]     idx_q;
  logic                              out_hs;
  logic                              is_last;
  logic signed [mcr_pkg::OFFSET_W-1:0] u;
  logic signed [mcr_pkg::OFFSET_W-1:0] v;
  logic [mcr_pkg::PIXEL_W-1:0]       cx_ext;
  logic [mcr_pkg::PIXEL_W-1:0]       cy_ext;
  logic [mcr_pkg::PIXEL_W-1:0]       u_ext;
  logic [mcr_pkg::PIXEL_W-1:0]       v_ext;
  logic [mcr_pkg::PIXEL_W-1:0]       pixel_x;
  logic [mcr_pkg::PIXEL_W-1:0]       pixel_y;

  assign is_last       = (idx_q == mcr_pkg::PIX_IDX_LAST);
  assign out_hs        = valid_q && m_axis_tready_i;
  assign group_ready_o = !valid_q || (out_hs && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (group_valid_i && group_ready_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (out_hs) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (group_valid_i && group_ready_o) begin
      grp_q <= group_i;
    end
  end

  // The upper half of the group swaps the roles of the two offsets; bit 0
  // mirrors the column and bit 1 mirrors the row.
  always_comb begin
    u       = idx_q[2] ? grp_q.b : grp_q.a;
    v       = idx_q[2] ? grp_q.a : grp_q.b;
    cx_ext  = mcr_pkg::PIXEL_W'(grp_q.cx);
    cy_ext  = mcr_pkg::PIXEL_W'(grp_q.cy);
    u_ext   = mcr_pkg::PIXEL_W'(u);
    v_ext   = mcr_pkg::PIXEL_W'(v);
    pixel_x = idx_q[0] ? (cx_ext - u_ext) : (cx_ext + u_ext);
    pixel_y = idx_q[1] ? (cy_ext - v_ext) : (cy_ext + v_ext);
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {4'b0000, color_i, pixel_y, pixel_x};
  assign m_axis_tlast_o  = is_last;
  assign m_axis_tuser_o  = grp_q.done;

endmodule
